[src/hex_text_frame_parser_macros.svh]
// Assertion macros for the hex text frame parser.
// Included by the top level; relies on nothing else.
`ifndef HEX_TEXT_FRAME_PARSER_MACROS_SVH
`define HEX_TEXT_FRAME_PARSER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define HTFP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hex text frame parser: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define HTFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hex text frame parser: next-cycle check failed");

`endif

[src/htfp_pkg.sv]
// Shared types and constants of the hex text frame parser.
// No dependencies; imported by the result interface, the design modules and the testbench.
package htfp_pkg;

  // Largest number of payload bytes after the command byte.
  localparam int MAX_PAYLOAD = 31;
  localparam logic [7:0] MAX_BYTES = 8'(MAX_PAYLOAD + 1);

  // Character codes used by the decoder.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] DIGIT_TEN  = 8'd10;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FORMAT   = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  // Classification of one character.
  typedef struct packed {
    logic       is_sep;
    logic       is_hex;
    logic [3:0] nibble;
  } char_class_t;

  // One result word.
  typedef struct packed {
    kind_t      result_kind;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    status_t    status;
    logic [7:0] payload_length;
  } result_t;

endpackage

[src/htfp_char_if.sv]
// Character channel of the hex text frame parser.
// No dependencies.
interface htfp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

[src/htfp_result_if.sv]
// Result channel of the hex text frame parser.
// Uses the status and kind types of htfp_pkg.
interface htfp_result_if import htfp_pkg::*; ;
  logic       valid;
  logic       ready;
  kind_t      result_kind;
  logic [7:0] byte_value;
  logic [7:0] byte_index;
  status_t    status;
  logic [7:0] payload_length;

  modport source (output valid, output result_kind, output byte_value, output byte_index,
                  output status, output payload_length, input ready);
  modport sink   (input valid, input result_kind, input byte_value, input byte_index,
                  input status, input payload_length, output ready);
endinterface

[src/htfp_char_decode.sv]
// Character classifier: separator, hex digit and nibble value.
// Uses the character constants of htfp_pkg.
module htfp_char_decode import htfp_pkg::*; (
  input  logic [7:0]  text_char,
  output char_class_t char_class
);

  logic [7:0] offset;

  // Classify and map hex digits of either case onto a nibble
  always_comb begin
    offset = 8'd0;
    char_class.is_sep = text_char inside {CH_SPACE, CH_CR, CH_LF, CH_TAB, CH_DASH, CH_COLON};
    char_class.is_hex = 1'b1;
    if (text_char inside {[CH_ZERO:CH_NINE]}) begin
      offset = text_char - CH_ZERO;
    end else if (text_char inside {[CH_UPPER_A:CH_UPPER_F]}) begin
      offset = text_char - CH_UPPER_A + DIGIT_TEN;
    end else if (text_char inside {[CH_LOWER_A:CH_LOWER_F]}) begin
      offset = text_char - CH_LOWER_A + DIGIT_TEN;
    end else begin
      char_class.is_hex = 1'b0;
    end
    char_class.nibble = offset[3:0];
  end

endmodule

[src/htfp_frame_core.sv]
// Frame state: nibble pairing, byte count, sticky error and end-of-text status.
// Uses htfp_pkg types; fed by htfp_char_decode.
module htfp_frame_core import htfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        end_of_text,
  input  char_class_t char_class,
  output logic        push_valid,
  output result_t     push_data
);

  logic       nibble_pending, nibble_pending_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  status_t    error_code, error_code_next;
  logic       produce;

  // Work out the next state and any result of the current word
  always_comb begin
    nibble_pending_next = nibble_pending;
    high_nibble_next    = high_nibble;
    bytes_seen_next     = bytes_seen;
    error_code_next     = error_code;
    produce             = 1'b0;
    push_data           = '0;
    if (end_of_text) begin
      produce               = 1'b1;
      push_data.result_kind = KIND_STATUS;
      if (error_code != ST_OK) begin
        push_data.status = error_code;
      end else if (nibble_pending) begin
        push_data.status = ST_FORMAT;
      end else if (bytes_seen == 8'd0) begin
        push_data.status = ST_EMPTY;
      end else begin
        push_data.status         = ST_OK;
        push_data.payload_length = bytes_seen - 8'd1;
      end
      nibble_pending_next = 1'b0;
      high_nibble_next    = 4'd0;
      bytes_seen_next     = 8'd0;
      error_code_next     = ST_OK;
    end else if (error_code == ST_OK && !char_class.is_sep) begin
      if (!char_class.is_hex) begin
        error_code_next = ST_FORMAT;
      end else if (!nibble_pending) begin
        nibble_pending_next = 1'b1;
        high_nibble_next    = char_class.nibble;
      end else begin
        nibble_pending_next = 1'b0;
        high_nibble_next    = 4'd0;
        if (bytes_seen >= MAX_BYTES) begin
          // Drop the byte and latch overflow
          error_code_next = ST_OVERFLOW;
        end else begin
          produce               = 1'b1;
          push_data.result_kind = KIND_BYTE;
          push_data.byte_value  = {high_nibble, char_class.nibble};
          push_data.byte_index  = bytes_seen;
          bytes_seen_next       = bytes_seen + 8'd1;
        end
      end
    end
  end

  assign push_valid = accept && produce;

  // Hold frame state; advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_pending <= 1'b0;
      high_nibble    <= 4'd0;
      bytes_seen     <= 8'd0;
      error_code     <= ST_OK;
    end else if (accept) begin
      nibble_pending <= nibble_pending_next;
      high_nibble    <= high_nibble_next;
      bytes_seen     <= bytes_seen_next;
      error_code     <= error_code_next;
    end
  end

endmodule

[src/htfp_out_skid.sv]
// Output register with a spare entry, so that ready towards the source is registered.
// Uses result_t of htfp_pkg.
module htfp_out_skid import htfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  input  result_t push_data,
  output logic    push_ready,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_ready
);

  logic    spare_valid;
  result_t spare_data;

  assign push_ready = !spare_valid;

  // Move words from the core into the output register or the spare
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (spare_valid) begin
          out_valid   <= 1'b1;
          out_data    <= spare_data;
          spare_valid <= 1'b0;
        end else begin
          out_valid <= push_valid;
          if (push_valid) begin
            out_data <= push_data;
          end
        end
      end else if (push_valid && !spare_valid) begin
        // Receiver stalled: park the new word
        spare_valid <= 1'b1;
        spare_data  <= push_data;
      end
    end
  end

endmodule

[src/hex_text_frame_parser.sv]
// Hex text frame parser, top level.
// Depends on htfp_pkg, the two channel interfaces, htfp_char_decode,
// htfp_frame_core, htfp_out_skid and the assertion macro header.
//
// Usage:
//   chars   - one ASCII character per word, or an end-of-text marker word.
//   results - decoded bytes (kind byte, with index; index 0 is the command)
//             and one status word per frame at end of text (ok, format,
//             overflow or empty, with payload length when ok).
//   Separators (space, tab, CR, LF, '-' and ':') produce nothing. After an
//   error every character up to end of text is ignored; bytes already sent
//   for that frame must be dropped by the receiver.
//   Results are registered in the output stage. Throughput: one character
//   per cycle while chars.ready is high, set by the single decode-and-update
//   step of the frame state register.
//   Reset (rst, synchronous) empties the output stage and clears the frame
//   state. When the receiver stalls, one further result is parked in a spare
//   register; chars.ready then drops until the spare drains, so no word is
//   lost.
`include "hex_text_frame_parser_macros.svh"

module hex_text_frame_parser import htfp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  htfp_char_if.sink     chars,
  htfp_result_if.source results
);

  char_class_t char_class;
  logic        accept;
  logic        push_valid;
  logic        push_ready;
  result_t     push_data;
  result_t     out_data;

  assign chars.ready = push_ready;
  assign accept      = chars.valid && push_ready;

  htfp_char_decode u_decode (
    .text_char  (chars.text_char),
    .char_class (char_class)
  );

  htfp_frame_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .end_of_text (chars.end_of_text),
    .char_class  (char_class),
    .push_valid  (push_valid),
    .push_data   (push_data)
  );

  htfp_out_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_valid  (results.valid),
    .out_data   (out_data),
    .out_ready  (results.ready)
  );

  // Drive the result channel fields
  assign results.result_kind    = out_data.result_kind;
  assign results.byte_value     = out_data.byte_value;
  assign results.byte_index     = out_data.byte_index;
  assign results.status         = out_data.status;
  assign results.payload_length = out_data.payload_length;

  // End of text always yields a status word
  `HTFP_ASSERT_SAME(eot_gives_status, clk, rst, accept && chars.end_of_text,
                    push_valid && push_data.result_kind == KIND_STATUS)
  // The result channel is valid in the next cycle
  `HTFP_ASSERT_NEXT(eot_result_shown, clk, rst, accept && chars.end_of_text, results.valid)
  // Byte indexes stay within the frame limit
  `HTFP_ASSERT_SAME(index_in_range, clk, rst,
                    push_valid && push_data.result_kind == KIND_BYTE,
                    push_data.byte_index < MAX_BYTES)
  // Payload length is reported only for a good frame
  `HTFP_ASSERT_SAME(length_only_ok, clk, rst,
                    results.valid && results.result_kind == KIND_STATUS
                    && results.status != ST_OK,
                    results.payload_length == 8'd0)

endmodule

[verif/hex_text_frame_parser_test.sv]
// Self-checking testbench of hex_text_frame_parser: directed words, an overflow frame, then random frames.
// Depends on htfp_pkg, htfp_char_if, htfp_result_if and the parser top level.
`timescale 1ns / 1ps

module hex_text_frame_parser_test;
  import htfp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 450;
  localparam int HOLD_CYCLES = 120;
  localparam int TAIL_CYCLES = 8;

  // Typed expectations for the directed rows
  localparam result_t R_NONE    = '{KIND_BYTE, 8'h00, 8'h00, ST_OK, 8'h00};
  localparam result_t R_EMPTY   = '{KIND_STATUS, 8'h00, 8'h00, ST_EMPTY, 8'h00};
  localparam result_t R_FORMAT  = '{KIND_STATUS, 8'h00, 8'h00, ST_FORMAT, 8'h00};
  localparam result_t R_BYTE_00 = '{KIND_BYTE, 8'h00, 8'h00, ST_OK, 8'h00};
  localparam result_t R_BYTE_FF = '{KIND_BYTE, 8'hFF, 8'h01, ST_OK, 8'h00};

  localparam logic [7:0] SEPARATORS [6] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_DASH, CH_COLON};

  // One directed word; typed rows carry their own expectation
  typedef struct packed {
    logic [7:0] chr;
    logic       eot;
    logic       typed;
    logic       some;
    result_t    res;
  } stim_row_t;

  localparam stim_row_t DIRECTED [25] = '{
    '{8'hFF,      1'b1, 1'b1, 1'b1, R_EMPTY},    // end of text straight after reset
    '{CH_ZERO,    1'b0, 1'b1, 1'b0, R_NONE},
    '{CH_ZERO,    1'b0, 1'b1, 1'b1, R_BYTE_00},  // smallest byte, command position
    '{CH_SPACE,   1'b0, 1'b0, 1'b0, R_NONE},
    '{CH_UPPER_F, 1'b0, 1'b0, 1'b0, R_NONE},
    '{CH_LOWER_F, 1'b0, 1'b1, 1'b1, R_BYTE_FF},  // largest byte, mixed case
    '{CH_TAB,     1'b0, 1'b0, 1'b0, R_NONE},
    '{CH_CR,      1'b0, 1'b0, 1'b0, R_NONE},
    '{CH_LF,      1'b0, 1'b0, 1'b0, R_NONE},
    '{CH_DASH,    1'b0, 1'b0, 1'b0, R_NONE},
    '{CH_COLON,   1'b0, 1'b0, 1'b0, R_NONE},
    '{CH_LOWER_A, 1'b0, 1'b0, 1'b0, R_NONE},
    '{CH_NINE,    1'b0, 1'b0, 1'b0, R_NONE},
    '{CH_UPPER_A, 1'b0, 1'b0, 1'b0, R_NONE},
    '{8'h62,      1'b0, 1'b0, 1'b0, R_NONE},
    '{8'h00,      1'b1, 1'b0, 1'b0, R_NONE},     // good frame, length from prediction
    '{8'h37,      1'b0, 1'b0, 1'b0, R_NONE},
    '{CH_SPACE,   1'b1, 1'b1, 1'b1, R_FORMAT},   // dangling nibble
    '{8'h00,      1'b0, 1'b1, 1'b0, R_NONE},     // non-hex character
    '{8'h31,      1'b0, 1'b1, 1'b0, R_NONE},     // ignored after the error
    '{8'h32,      1'b0, 1'b1, 1'b0, R_NONE},
    '{8'h00,      1'b1, 1'b1, 1'b1, R_FORMAT},
    '{8'hFF,      1'b0, 1'b1, 1'b0, R_NONE},
    '{8'h45,      1'b1, 1'b1, 1'b1, R_FORMAT},
    '{8'h00,      1'b1, 1'b1, 1'b1, R_EMPTY}     // state cleared after the error
  };

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_EVERY_THIRD, RX_MOSTLY} rx_mode_t;

  logic clk;
  logic rst;

  htfp_char_if   char_bus();
  htfp_result_if result_bus();

  hex_text_frame_parser uut (
    .clk(clk),
    .rst(rst),
    .chars(char_bus),
    .results(result_bus)
  );

  // Predicted frame state
  logic       nib_pend = 1'b0;
  logic [3:0] hi_nib = 4'h0;
  logic [7:0] byte_count = 8'h00;
  status_t    frame_err = ST_OK;

  result_t exp_q [$];

  // Expectation attached to the word on offer
  logic    cur_typed = 1'b0;
  logic    cur_some = 1'b0;
  result_t cur_res = R_NONE;

  int errors = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int live_items = 0;
  int results_checked = 0;
  int bytes_checked = 0;
  int status_count [4] = '{0, 0, 0, 0};
  int burst_left = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int rx_tick = 0;
  rx_mode_t rx_mode = RX_FREE;

  function automatic bit is_sep_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
           c == CH_DASH || c == CH_COLON;
  endfunction

  function automatic bit hex_digit_val(input logic [7:0] c, output logic [3:0] nib);
    nib = 4'h0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      nib = 4'(c - CH_ZERO);
      return 1'b1;
    end
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      nib = 4'(c - CH_UPPER_A + DIGIT_TEN);
      return 1'b1;
    end
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      nib = 4'(c - CH_LOWER_A + DIGIT_TEN);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the predicted frame state by one word; return 1 when a result is due
  function automatic bit predict_word(input logic [7:0] c, input logic eot,
                                      output result_t r);
    logic [3:0] nib;
    r = R_NONE;
    if (eot) begin
      r.result_kind = KIND_STATUS;
      if (frame_err != ST_OK) r.status = frame_err;
      else if (nib_pend) r.status = ST_FORMAT;
      else if (byte_count == 8'h00) r.status = ST_EMPTY;
      else begin
        r.status = ST_OK;
        r.payload_length = byte_count - 8'd1;
      end
      nib_pend = 1'b0;
      hi_nib = 4'h0;
      byte_count = 8'h00;
      frame_err = ST_OK;
      return 1'b1;
    end
    if (frame_err != ST_OK || is_sep_char(c)) return 1'b0;
    if (!hex_digit_val(c, nib)) begin
      frame_err = ST_FORMAT;
      return 1'b0;
    end
    if (!nib_pend) begin
      nib_pend = 1'b1;
      hi_nib = nib;
      return 1'b0;
    end
    nib_pend = 1'b0;
    // Drop the byte and the nibble once the frame is full
    if (byte_count >= MAX_BYTES) begin
      hi_nib = 4'h0;
      frame_err = ST_OVERFLOW;
      return 1'b0;
    end
    r.byte_value = {hi_nib, nib};
    r.byte_index = byte_count;
    byte_count = byte_count + 8'd1;
    hi_nib = 4'h0;
    return 1'b1;
  endfunction

  task automatic field_check(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, exp_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check accepted results, then predict from the accepted character word
  always @(posedge clk) begin
    result_t want;
    result_t pred;
    bit due;
    if (!rst) begin
      if (result_bus.valid && result_bus.ready) begin
        if (exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual kind %0d value %0h",
                   $time, result_bus.result_kind, result_bus.byte_value);
        end else begin
          want = exp_q.pop_front();
          field_check("result_kind", 8'(want.result_kind), 8'(result_bus.result_kind));
          field_check("byte_value", want.byte_value, result_bus.byte_value);
          field_check("byte_index", want.byte_index, result_bus.byte_index);
          field_check("status", 8'(want.status), 8'(result_bus.status));
          field_check("payload_length", want.payload_length, result_bus.payload_length);
          results_checked++;
        end
      end
      if (char_bus.valid && char_bus.ready) begin
        if (char_bus.end_of_text || frame_err == ST_OK) live_items++;
        due = predict_word(char_bus.text_char, char_bus.end_of_text, pred);
        if (due) begin
          if (pred.result_kind == KIND_STATUS) status_count[pred.status]++;
          else bytes_checked++;
        end
        if (cur_typed) begin
          if (cur_some) exp_q.push_back(cur_res);
        end else if (due) begin
          exp_q.push_back(pred);
        end
      end
    end
  end

  // Receiver: stall patterns that change now and then, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else begin
      if (rx_tick % 97 == 0) rx_mode = rx_mode_t'($urandom_range(3));
      case (rx_mode)
        RX_FREE: begin
          result_bus.ready <= 1'b1;
        end
        RX_COIN: begin
          result_bus.ready <= 1'($urandom_range(1));
        end
        RX_EVERY_THIRD: begin
          result_bus.ready <= (rx_tick % 3) != 0;
        end
        default: begin
          result_bus.ready <= $urandom_range(9) != 0;
        end
      endcase
    end
  end

  // Offer one character word and hold it until taken; sometimes idle between bursts
  task automatic put_char(input logic [7:0] c, input logic eot);
    int gap;
    @(negedge clk);
    char_bus.valid <= 1'b1;
    char_bus.text_char <= c;
    char_bus.end_of_text <= eot;
    do @(posedge clk); while (!char_bus.ready);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        char_bus.valid <= 1'b0;
        char_bus.text_char <= 8'($urandom_range(255));
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic wait_drained();
    @(negedge clk);
    char_bus.valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Send one frame of hex digit pairs, with separators, optional faults and end of text
  task automatic send_frame(input int n_bytes, input bit bad, input bit dangling,
                            input bit noisy);
    int total;
    int bad_at;
    int d;
    logic [3:0] nib;
    logic [3:0] v;
    logic [7:0] c;
    total = 2 * n_bytes + (dangling ? 1 : 0);
    bad_at = bad ? int'($urandom_range(total)) : -1;
    for (d = 0; d <= total; d++) begin
      if (d == bad_at) begin
        if (noisy) c = 8'($urandom_range(255));
        else do c = 8'($urandom_range(255)); while (is_sep_char(c) || hex_digit_val(c, nib));
        put_char(c, 1'b0);
      end
      if (d < total) begin
        if ($urandom_range(5) == 0) put_char(SEPARATORS[$urandom_range(5)], 1'b0);
        v = 4'($urandom_range(15));
        if (v < 4'd10) c = CH_ZERO + 8'(v);
        else c = ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v) - DIGIT_TEN;
        put_char(c, 1'b0);
      end
    end
    put_char(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    int frame_no;
    int pick;
    int n_bytes;
    int goal;
    rst = 1'b1;
    char_bus.valid = 1'b0;
    char_bus.text_char = 8'h00;
    char_bus.end_of_text = 1'b0;
    result_bus.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words; the expectation changes only after the checker has seen the edge
    foreach (DIRECTED[i]) begin
      cur_typed <= DIRECTED[i].typed;
      cur_some <= DIRECTED[i].some;
      cur_res <= DIRECTED[i].res;
      put_char(DIRECTED[i].chr, DIRECTED[i].eot);
    end
    cur_typed <= 1'b0;
    wait_drained();

    // Overflowing frame against a long receiver hold-off, then a full legal frame
    hold_req = 1'b1;
    send_frame(int'(MAX_BYTES) + 4, 1'b0, 1'b0, 1'b0);
    send_frame(int'(MAX_BYTES), 1'b0, 1'b0, 1'b0);
    wait_drained();

    // Random frames, mostly well formed
    goal = live_items + RANDOM_WORDS;
    frame_no = 0;
    while (live_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 15) n_bytes = $urandom_range(2);
      else if (pick < 75) n_bytes = $urandom_range(3, 6);
      else if (pick < 92) n_bytes = $urandom_range(7, int'(MAX_BYTES));
      else n_bytes = $urandom_range(int'(MAX_BYTES), int'(MAX_BYTES) + 2);
      send_frame(n_bytes, $urandom_range(99) < 12, $urandom_range(99) < 8,
                 1'($urandom_range(1)));
      frame_no++;
      if (frame_no % 25 == 0) hold_req = 1'b1;
      if (frame_no % 12 == 0) wait_drained();
    end
    wait_drained();

    $display("Covered %0d character words (%0d not ignored), %0d results checked, %0d bytes",
             words_sent, live_items, results_checked, bytes_checked);
    $display("Frame status: ok %0d, format %0d, overflow %0d, empty %0d",
             status_count[ST_OK], status_count[ST_FORMAT], status_count[ST_OVERFLOW],
             status_count[ST_EMPTY]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/htfp_pkg.sv
src/htfp_char_if.sv
src/htfp_result_if.sv
src/htfp_char_decode.sv
src/htfp_frame_core.sv
src/htfp_out_skid.sv
src/hex_text_frame_parser.sv
verif/hex_text_frame_parser_test.sv
